// ===== rtl/core/tdbl_pkg.sv =====
// Shared types and constants for the tree distance binary lifting unit.
// Used by the controller, the datapath and the top level; no dependencies.
package tdbl_pkg;

    localparam int NODE_W      = 10;
    localparam int MAX_NODES   = 1 << NODE_W;
    localparam int LIFT_LEVELS = 10;
    localparam int LVL_W       = $clog2(LIFT_LEVELS);
    localparam int DEPTH_W     = 10;
    localparam int DIST_W      = 11;
    localparam int SUM_W       = DIST_W + 1;
    localparam int ANC_ADDR_W  = NODE_W + LVL_W;
    localparam int ANC_WORDS   = 1 << ANC_ADDR_W;

    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;
    localparam int M_PAD_W     = M_TDATA_W - DIST_W - NODE_W;

    localparam logic [LVL_W-1:0]   LVL_LAST     = LVL_W'(LIFT_LEVELS - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX    = DEPTH_W'(1023);
    localparam logic [DIST_W-1:0]  DIST_MAX     = DIST_W'(2046);
    localparam logic [DIST_W-1:0]  NO_PATH_DIST = DIST_W'(2047);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [1:0] sel_t;

    // Node source for the ancestor table read address.
    localparam sel_t ASEL_X    = 2'd0;
    localparam sel_t ASEL_Y    = 2'd1;
    localparam sel_t ASEL_PREV = 2'd2;

    // Node source for the depth table read address.
    localparam sel_t DSEL_A    = 2'd0;
    localparam sel_t DSEL_B    = 2'd1;
    localparam sel_t DSEL_LCA  = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [NODE_W-1:0]   node;
    } anc_entry_t;

    typedef struct packed {
        logic load_in;
        logic dep_rd_en;
        sel_t dep_sel;
        logic dep_wr_root;
        logic dep_wr_child;
        logic dep_cap_a;
        logic order;
        logic anc_rd_en;
        sel_t anc_sel;
        logic anc_wr_en;
        logic anc_wr_zero;
        logic prev_init;
        logic prev_cap;
        logic lvl_inc;
        logic lvl_top;
        logic lvl_dec;
        logic x_lift;
        logic ea_cap;
        logic climb;
        logic res_eq;
        logic res_nopath;
        logic res_final;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_root;
        logic lvl_last;
        logic lvl_zero;
        logic diff_bit;
        logic prev_valid;
        logic rd_valid;
        logic x_eq_y;
        logic final_ok;
    } stat_t;

endpackage

// ===== rtl/core/tree_distance_binary_lifting_unit.sv =====
// Top level of the tree distance binary lifting unit: ties the controller to
// the datapath. Depends on tdbl_pkg, tdbl_ctrl and tdbl_dpath.
//
//  Channel  Direction  Payload
//  s_*      in         tdata: node_a[9:0], node_b[19:10]; tuser: req_type[0], is_root[1]
//  m_*      out        tdata: distance[10:0], common_ancestor[20:11]
//
// One item at a time. A root load clears every lift level. A child load writes
// each level; below the top level, whenever the ancestor just written is valid,
// it also reads back and captures the next one. A query skips the climb when the
// lifted node meets the other one: the single port of the ancestor memory is
// read once per lift step and twice per climb level. Reset is synchronous and
// clears only control state; the tables hold undefined values until loaded.
// A stalled result waits in the output register while the next item is
// accepted and worked on.
module tree_distance_binary_lifting_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // node_a [9:0], node_b [19:10], zeros [23:20]
    input  logic [tdbl_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [0], is_root [1]
    input  logic [tdbl_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // distance [10:0], common_ancestor [20:11], zeros [23:21]
    output logic [tdbl_pkg::M_TDATA_W-1:0] m_tdata
);
    import tdbl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tdbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tdbl_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule

// ===== rtl/core/tdbl_dpath.sv =====
// Datapath: ancestor and depth memories, node and level registers, result
// arithmetic and the output data register. Depends on tdbl_pkg.
module tdbl_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tdbl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tdbl_pkg::S_TUSER_W-1:0] s_tuser,
    input  tdbl_pkg::cmd_t                cmd,
    output tdbl_pkg::stat_t               stat,
    output logic [tdbl_pkg::M_TDATA_W-1:0] m_tdata
);
    import tdbl_pkg::*;

    anc_entry_t anc_mem [ANC_WORDS];
    logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

    logic [NODE_W-1:0]  a_reg, b_reg, x_reg, y_reg;
    anc_entry_t         prev_reg, ea_reg, anc_rd_reg;
    logic [DEPTH_W-1:0] da_reg, diff_reg, dsh_reg, dep_rd_reg;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [DIST_W-1:0]  res_dist_reg, out_dist_reg;
    logic [NODE_W-1:0]  res_lca_reg, out_lca_reg;

    logic [NODE_W-1:0]     in_node_a, in_node_b, dep_ra, anc_node;
    logic [ANC_ADDR_W-1:0] anc_ra, anc_wa;
    anc_entry_t            anc_wd;
    logic [DEPTH_W:0]      dep_inc;
    logic [DEPTH_W-1:0]    dep_wd, gap;
    logic                  dep_we, swap;
    logic [SUM_W-1:0]      total;
    logic [DIST_W-1:0]     final_dist;

    assign in_node_a = s_tdata[NODE_W-1:0];
    assign in_node_b = s_tdata[2*NODE_W-1:NODE_W];

    always_comb begin
        unique case (cmd.dep_sel)
            DSEL_B:   dep_ra = b_reg;
            DSEL_LCA: dep_ra = ea_reg.node;
            default:  dep_ra = a_reg;
        endcase
        unique case (cmd.anc_sel)
            ASEL_Y:    anc_node = y_reg;
            ASEL_PREV: anc_node = prev_reg.node;
            default:   anc_node = x_reg;
        endcase
    end

    // A child sits one level below its parent, saturating at the top depth.
    assign dep_inc = {1'b0, dep_rd_reg} + (DEPTH_W + 1)'(1);
    assign dep_wd  = cmd.dep_wr_root ? '0 :
                     (dep_inc > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : dep_inc[DEPTH_W-1:0];
    assign dep_we  = cmd.dep_wr_root | cmd.dep_wr_child;

    assign anc_ra = {anc_node, lvl_reg};
    assign anc_wa = {a_reg, lvl_reg};
    assign anc_wd = cmd.anc_wr_zero ? '0 : prev_reg;

    always_ff @(posedge aclk) begin
        if (dep_we) begin
            dep_mem[a_reg] <= dep_wd;
        end
        if (cmd.dep_rd_en) begin
            dep_rd_reg <= dep_mem[dep_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.anc_wr_en) begin
            anc_mem[anc_wa] <= anc_wd;
        end
        if (cmd.anc_rd_en) begin
            anc_rd_reg <= anc_mem[anc_ra];
        end
    end

    // Path length adds twice the climb from the shallower node to the ancestor.
    assign gap        = (dep_rd_reg < dsh_reg) ? (dsh_reg - dep_rd_reg) : '0;
    assign total      = {2'b00, diff_reg} + {1'b0, gap, 1'b0};
    assign final_dist = (total > {1'b0, DIST_MAX}) ? DIST_MAX : total[DIST_W-1:0];
    assign swap       = da_reg < dep_rd_reg;

    always_comb begin
        lvl_next = lvl_reg;
        priority if (cmd.load_in) begin
            lvl_next = '0;
        end else if (cmd.lvl_top) begin
            lvl_next = LVL_LAST;
        end else if (cmd.lvl_inc) begin
            lvl_next = lvl_reg + LVL_W'(1);
        end else if (cmd.lvl_dec) begin
            lvl_next = lvl_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= '0;
        end else begin
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= in_node_a;
            b_reg <= in_node_b;
        end
        if (cmd.dep_cap_a) begin
            da_reg <= dep_rd_reg;
        end
        if (cmd.prev_init) begin
            prev_reg <= '{valid: 1'b1, node: b_reg};
        end else if (cmd.prev_cap) begin
            prev_reg <= anc_rd_reg.valid ? anc_rd_reg : '0;
        end
        if (cmd.ea_cap) begin
            ea_reg <= anc_rd_reg;
        end
        if (cmd.order) begin
            if (swap) begin
                x_reg    <= b_reg;
                y_reg    <= a_reg;
                diff_reg <= dep_rd_reg - da_reg;
                dsh_reg  <= da_reg;
            end else begin
                x_reg    <= a_reg;
                y_reg    <= b_reg;
                diff_reg <= da_reg - dep_rd_reg;
                dsh_reg  <= dep_rd_reg;
            end
        end else if (cmd.x_lift) begin
            x_reg <= anc_rd_reg.node;
        end else if (cmd.climb) begin
            if (ea_reg.valid && anc_rd_reg.valid && (ea_reg != anc_rd_reg)) begin
                x_reg <= ea_reg.node;
                y_reg <= anc_rd_reg.node;
            end
        end
        if (cmd.res_eq) begin
            res_dist_reg <= {{(DIST_W - DEPTH_W){1'b0}}, diff_reg};
            res_lca_reg  <= y_reg;
        end else if (cmd.res_nopath) begin
            res_dist_reg <= NO_PATH_DIST;
            res_lca_reg  <= '0;
        end else if (cmd.res_final) begin
            res_dist_reg <= final_dist;
            res_lca_reg  <= ea_reg.node;
        end
        if (cmd.publish) begin
            out_dist_reg <= res_dist_reg;
            out_lca_reg  <= res_lca_reg;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, out_lca_reg, out_dist_reg};

    always_comb begin
        stat.in_query   = (s_tuser[0] == REQ_QUERY);
        stat.in_root    = s_tuser[1];
        stat.lvl_last   = (lvl_reg == LVL_LAST);
        stat.lvl_zero   = (lvl_reg == '0);
        stat.diff_bit   = diff_reg[lvl_reg];
        stat.prev_valid = prev_reg.valid;
        stat.rd_valid   = anc_rd_reg.valid;
        stat.x_eq_y     = (x_reg == y_reg);
        stat.final_ok   = ea_reg.valid && (ea_reg == anc_rd_reg);
    end

    a_lvl_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LVL_LAST)
        else $error("level counter ran past the top lift level");

    a_lvl_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.lvl_inc && !cmd.load_in && !cmd.lvl_top) |-> lvl_reg != LVL_LAST)
        else $error("level increment requested at the top lift level");

endmodule

// ===== rtl/core/tdbl_ctrl.sv =====
// Controller: sequences loads and queries over the datapath and owns the
// handshake state of both channels. Depends on tdbl_pkg.
module tdbl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  tdbl_pkg::stat_t  stat,
    output tdbl_pkg::cmd_t   cmd
);
    import tdbl_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] L_ZERO  = 5'd1;
    localparam logic [4:0] L_RDDEP = 5'd2;
    localparam logic [4:0] L_WRDEP = 5'd3;
    localparam logic [4:0] L_WR    = 5'd4;
    localparam logic [4:0] L_RD    = 5'd5;
    localparam logic [4:0] L_CAP   = 5'd6;
    localparam logic [4:0] Q_RDA   = 5'd7;
    localparam logic [4:0] Q_RDB   = 5'd8;
    localparam logic [4:0] Q_CMP   = 5'd9;
    localparam logic [4:0] Q_LIFT  = 5'd10;
    localparam logic [4:0] Q_LCAP  = 5'd11;
    localparam logic [4:0] Q_EQ    = 5'd12;
    localparam logic [4:0] Q_CA    = 5'd13;
    localparam logic [4:0] Q_CB    = 5'd14;
    localparam logic [4:0] Q_CC    = 5'd15;
    localparam logic [4:0] Q_FA    = 5'd16;
    localparam logic [4:0] Q_FB    = 5'd17;
    localparam logic [4:0] Q_FC    = 5'd18;
    localparam logic [4:0] Q_FD    = 5'd19;
    localparam logic [4:0] S_PUB   = 5'd20;

    logic [4:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    priority if (stat.in_query) begin
                        state_next = Q_RDA;
                    end else if (stat.in_root) begin
                        state_next = L_ZERO;
                    end else begin
                        state_next = L_RDDEP;
                    end
                end
            end
            L_ZERO: begin
                cmd.anc_wr_en   = 1'b1;
                cmd.anc_wr_zero = 1'b1;
                cmd.dep_wr_root = 1'b1;
                if (stat.lvl_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.lvl_inc = 1'b1;
                end
            end
            L_RDDEP: begin
                cmd.dep_rd_en = 1'b1;
                cmd.dep_sel   = DSEL_B;
                cmd.prev_init = 1'b1;
                state_next    = L_WRDEP;
            end
            L_WRDEP: begin
                cmd.dep_wr_child = 1'b1;
                state_next       = L_WR;
            end
            L_WR: begin
                cmd.anc_wr_en = 1'b1;
                priority if (stat.lvl_last) begin
                    state_next = S_IDLE;
                end else if (stat.prev_valid) begin
                    state_next = L_RD;
                end else begin
                    cmd.lvl_inc = 1'b1;
                end
            end
            L_RD: begin
                // The previous ancestor's entry at the level just written is read next.
                cmd.anc_rd_en = 1'b1;
                cmd.anc_sel   = ASEL_PREV;
                state_next    = L_CAP;
            end
            L_CAP: begin
                cmd.prev_cap = 1'b1;
                cmd.lvl_inc  = 1'b1;
                state_next   = L_WR;
            end
            Q_RDA: begin
                cmd.dep_rd_en = 1'b1;
                cmd.dep_sel   = DSEL_A;
                state_next    = Q_RDB;
            end
            Q_RDB: begin
                cmd.dep_cap_a = 1'b1;
                cmd.dep_rd_en = 1'b1;
                cmd.dep_sel   = DSEL_B;
                state_next    = Q_CMP;
            end
            Q_CMP: begin
                cmd.order  = 1'b1;
                state_next = Q_LIFT;
            end
            Q_LIFT: begin
                priority if (stat.diff_bit) begin
                    cmd.anc_rd_en = 1'b1;
                    cmd.anc_sel   = ASEL_X;
                    state_next    = Q_LCAP;
                end else if (stat.lvl_last) begin
                    state_next = Q_EQ;
                end else begin
                    cmd.lvl_inc = 1'b1;
                end
            end
            Q_LCAP: begin
                // An invalid ancestor ends the lift at the last valid node.
                priority if (!stat.rd_valid) begin
                    state_next = Q_EQ;
                end else if (stat.lvl_last) begin
                    cmd.x_lift = 1'b1;
                    state_next = Q_EQ;
                end else begin
                    cmd.x_lift  = 1'b1;
                    cmd.lvl_inc = 1'b1;
                    state_next  = Q_LIFT;
                end
            end
            Q_EQ: begin
                if (stat.x_eq_y) begin
                    cmd.res_eq = 1'b1;
                    state_next = S_PUB;
                end else begin
                    cmd.lvl_top = 1'b1;
                    state_next  = Q_CA;
                end
            end
            Q_CA: begin
                cmd.anc_rd_en = 1'b1;
                cmd.anc_sel   = ASEL_X;
                state_next    = Q_CB;
            end
            Q_CB: begin
                cmd.ea_cap    = 1'b1;
                cmd.anc_rd_en = 1'b1;
                cmd.anc_sel   = ASEL_Y;
                state_next    = Q_CC;
            end
            Q_CC: begin
                cmd.climb = 1'b1;
                if (stat.lvl_zero) begin
                    state_next = Q_FA;
                end else begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = Q_CA;
                end
            end
            Q_FA: begin
                cmd.anc_rd_en = 1'b1;
                cmd.anc_sel   = ASEL_X;
                state_next    = Q_FB;
            end
            Q_FB: begin
                cmd.ea_cap    = 1'b1;
                cmd.anc_rd_en = 1'b1;
                cmd.anc_sel   = ASEL_Y;
                state_next    = Q_FC;
            end
            Q_FC: begin
                if (stat.final_ok) begin
                    cmd.dep_rd_en = 1'b1;
                    cmd.dep_sel   = DSEL_LCA;
                    state_next    = Q_FD;
                end else begin
                    cmd.res_nopath = 1'b1;
                    state_next     = S_PUB;
                end
            end
            Q_FD: begin
                cmd.res_final = 1'b1;
                state_next    = S_PUB;
            end
            S_PUB: begin
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        priority if (cmd.publish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_tvalid_reg || m_tready))
        else $error("result published over an untaken result");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.anc_wr_en && cmd.anc_rd_en))
        else $error("ancestor memory read and written in the same cycle");

    a_pub_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_tvalid)
        else $error("published result not presented");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tree_distance_binary_lifting_unit: builds random
// forests and one full-depth chain, then checks every distance/ancestor answer.
// Depends on tdbl_pkg and the unit's RTL only.
module tb_top;
    import tdbl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        logic  req;
        node_t node_a;
        node_t node_b;
        logic  root;
    } tree_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        node_t             ancestor;
    } path_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    tree_distance_binary_lifting_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Stimulus bookkeeping: which nodes have been loaded at least once.
    tree_req_t pending_reqs [$];
    bit        is_loaded [MAX_NODES];
    node_t     loaded_nodes [$];

    // Predicted tree state and the answers still owed by the unit.
    anc_entry_t        lift_table [MAX_NODES][LIFT_LEVELS];
    logic [DEPTH_W-1:0] node_depth [MAX_NODES];
    path_t             expected_paths [$];
    path_t             want;
    path_t             got;

    int error_count  = 0;
    int load_count   = 0;
    int query_count  = 0;
    int nopath_count = 0;
    int sat_count    = 0;
    int cycle_count  = 0;

    int gap_left   = 0;
    int burst_left = 0;
    int ready_run  = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [DIST_W-1:0] clip_distance(int path_len);
        return (path_len > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(path_len);
    endfunction

    // Updates the predicted tables for one load; returns 1 when the depth saturated.
    function automatic logic apply_load(node_t a, node_t b, logic root);
        anc_entry_t step;
        int         i;
        int         d;
        if (root) begin
            for (i = 0; i < LIFT_LEVELS; i++) lift_table[a][i] = '0;
            node_depth[a] = '0;
            return 1'b0;
        end
        d = int'(node_depth[b]) + 1;
        node_depth[a] = (d > int'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(d);
        step.valid = 1'b1;
        step.node  = b;
        lift_table[a][0] = step;
        // Row a may be its own ancestor, so read after each level is written.
        for (i = 1; i < LIFT_LEVELS; i++) begin
            if (step.valid) step = lift_table[step.node][i-1];
            else step = '0;
            lift_table[a][i] = step;
        end
        return d > int'(DEPTH_MAX);
    endfunction

    function automatic path_t path_between(node_t a, node_t b);
        node_t x;
        node_t y;
        node_t tmp;
        node_t lca;
        int    dy;
        int    diff;
        int    path_len;
        int    i;
        path_t r;
        x = a;
        y = b;
        if (node_depth[x] < node_depth[y]) begin
            tmp = x;
            x = y;
            y = tmp;
        end
        dy = int'(node_depth[y]);
        diff = int'(node_depth[x]) - dy;
        path_len = diff;
        // Lifting stops at the last valid ancestor.
        for (i = 0; i < LIFT_LEVELS; i++) begin
            if (((diff >> i) & 1) != 0) begin
                if (!lift_table[x][i].valid) break;
                x = lift_table[x][i].node;
            end
        end
        if (x == y) begin
            r.distance = clip_distance(path_len);
            r.ancestor = y;
            return r;
        end
        for (i = LIFT_LEVELS - 1; i >= 0; i--) begin
            if (lift_table[x][i].valid && lift_table[y][i].valid &&
                lift_table[x][i].node != lift_table[y][i].node) begin
                x = lift_table[x][i].node;
                y = lift_table[y][i].node;
            end
        end
        if (!lift_table[x][0].valid || lift_table[x][0] != lift_table[y][0]) begin
            r.distance = NO_PATH_DIST;
            r.ancestor = '0;
            return r;
        end
        lca = lift_table[x][0].node;
        if (int'(node_depth[lca]) < dy) path_len += 2 * (dy - int'(node_depth[lca]));
        r.distance = clip_distance(path_len);
        r.ancestor = lca;
        return r;
    endfunction

    task automatic push_load(node_t a, node_t b, logic root);
        tree_req_t item;
        item = '{REQ_LOAD, a, b, root};
        pending_reqs = {pending_reqs, item};
        if (!is_loaded[a]) begin
            is_loaded[a] = 1'b1;
            loaded_nodes = {loaded_nodes, a};
        end
    endtask

    task automatic push_query(node_t a, node_t b);
        tree_req_t item;
        item = '{REQ_QUERY, a, b, 1'($urandom_range(0, 1))};
        pending_reqs = {pending_reqs, item};
    endtask

    function automatic node_t any_loaded();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    // A small random forest with loads and queries interleaved, plus some
    // reparenting (which may close a cycle) and fresh roots as noise.
    task automatic grow_forest(int n_loads, int n_roots, int chain_pct, int n_queries);
        node_t members [$];
        node_t a;
        node_t b;
        int    i;
        int    roll;
        int    loads_left;
        int    queries_left;
        for (i = 0; i < n_roots; i++) begin
            a = node_t'($urandom_range(0, MAX_NODES - 1));
            push_load(a, node_t'($urandom_range(0, MAX_NODES - 1)), 1'b1);
            members = {members, a};
        end
        loads_left = n_loads;
        queries_left = n_queries;
        while (loads_left > 0 || queries_left > 0) begin
            if (loads_left > 0 && (queries_left == 0 || $urandom_range(0, 99) < 50)) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    push_load(any_loaded(), any_loaded(), 1'b0);
                end else if (roll < 9) begin
                    a = node_t'($urandom_range(0, MAX_NODES - 1));
                    push_load(a, node_t'($urandom_range(0, MAX_NODES - 1)), 1'b1);
                    members = {members, a};
                end else begin
                    a = node_t'($urandom_range(0, MAX_NODES - 1));
                    if ($urandom_range(0, 99) < chain_pct) b = members[members.size() - 1];
                    else b = members[$urandom_range(0, members.size() - 1)];
                    push_load(a, b, 1'b0);
                    members = {members, a};
                end
                loads_left--;
            end else begin
                a = members[$urandom_range(0, members.size() - 1)];
                if ($urandom_range(0, 3) == 0) b = any_loaded();
                else b = members[$urandom_range(0, members.size() - 1)];
                push_query(a, b);
                queries_left--;
            end
        end
    endtask

    // Every node in one shuffled chain, so depth reaches its ceiling and lifts
    // use every level; then the old root is hung below the deepest node.
    task automatic deep_chain();
        node_t chain_order [MAX_NODES];
        node_t tmp;
        int    i;
        int    j;
        for (i = 0; i < MAX_NODES; i++) chain_order[i] = node_t'(i);
        for (i = MAX_NODES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = chain_order[i];
            chain_order[i] = chain_order[j];
            chain_order[j] = tmp;
        end
        push_load(chain_order[0], node_t'($urandom_range(0, MAX_NODES - 1)), 1'b1);
        for (i = 1; i < MAX_NODES; i++) begin
            push_load(chain_order[i], chain_order[i-1], 1'b0);
            if (i % 8 == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_query(chain_order[$urandom_range(0, i)], chain_order[i]);
                else
                    push_query(chain_order[$urandom_range(0, i)],
                               chain_order[$urandom_range(0, i)]);
            end
        end
        // Depth saturates here, and both nodes then climb through every level.
        push_load(chain_order[0], chain_order[MAX_NODES - 1], 1'b0);
        push_query(chain_order[0], chain_order[MAX_NODES - 1]);
        for (i = 0; i < 20; i++)
            push_query(chain_order[$urandom_range(0, MAX_NODES - 1)],
                       chain_order[$urandom_range(0, MAX_NODES - 1)]);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_tdata  <= {{(S_TDATA_W - 2 * NODE_W){1'b0}},
                             pending_reqs[0].node_b, pending_reqs[0].node_a};
                s_tuser  <= {pending_reqs[0].root, pending_reqs[0].req};
                s_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls, short ready runs and long open stretches in random order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b0;
                    ready_run <= $urandom_range(1, 12);
                end
                3: begin
                    m_tready <= 1'b1;
                    ready_run <= $urandom_range(30, 80);
                end
                default: begin
                    m_tready <= 1'b1;
                    ready_run <= $urandom_range(1, 10);
                end
            endcase
        end
    end

    // Checks each result transfer, then predicts from each input transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.distance = m_tdata[DIST_W-1:0];
                got.ancestor = m_tdata[DIST_W +: NODE_W];
                if (expected_paths.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual distance %0d ancestor %0d",
                             $time, got.distance, got.ancestor);
                    error_count++;
                end else begin
                    want = expected_paths.pop_front();
                    if (got.distance !== want.distance) begin
                        $display("%0t: distance mismatch: expected %0d, actual %0d",
                                 $time, want.distance, got.distance);
                        error_count++;
                    end
                    if (got.ancestor !== want.ancestor) begin
                        $display("%0t: common ancestor mismatch: expected %0d, actual %0d",
                                 $time, want.ancestor, got.ancestor);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == REQ_QUERY) begin
                    want = path_between(s_tdata[NODE_W-1:0], s_tdata[NODE_W +: NODE_W]);
                    expected_paths = {expected_paths, want};
                    query_count++;
                    if (want.distance == NO_PATH_DIST) nopath_count++;
                end else begin
                    if (apply_load(s_tdata[NODE_W-1:0], s_tdata[NODE_W +: NODE_W], s_tuser[1]))
                        sat_count++;
                    load_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d answers outstanding.",
                     cycle_count, expected_paths.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int f;

        // Directed part: extreme node numbers, both load kinds, queries where
        // one node is an ancestor, a common ancestor above both, different
        // roots, a reloaded node and a node that is its own parent.
        push_load(10'd0, 10'd1023, 1'b1);
        push_load(10'd1023, 10'd0, 1'b0);
        push_load(10'd512, 10'd1023, 1'b0);
        push_load(10'd341, 10'd0, 1'b0);
        push_load(10'd682, 10'd341, 1'b0);
        push_query(10'd0, 10'd0);
        push_query(10'd512, 10'd0);
        push_query(10'd0, 10'd512);
        push_query(10'd512, 10'd682);
        push_load(10'd700, 10'd0, 1'b1);
        push_load(10'd701, 10'd700, 1'b0);
        push_query(10'd700, 10'd512);
        push_query(10'd701, 10'd1023);
        // The old child of 1023 keeps the entries it was loaded with.
        push_load(10'd1023, 10'd682, 1'b0);
        push_query(10'd512, 10'd1023);
        push_query(10'd1023, 10'd341);
        push_load(10'd700, 10'd700, 1'b0);
        push_query(10'd701, 10'd700);
        push_query(10'd1023, 10'd1023);

        for (f = 0; f < 3; f++)
            grow_forest($urandom_range(25, 60), $urandom_range(1, 3),
                        $urandom_range(20, 90), $urandom_range(30, 60));
        deep_chain();
        for (f = 0; f < 2; f++)
            grow_forest($urandom_range(25, 60), $urandom_range(1, 3),
                        $urandom_range(20, 90), $urandom_range(30, 60));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_paths.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d loads (%0d with saturated depth) and %0d queries,",
                 load_count, sat_count, query_count);
        $display("%0d of which found no common ancestor; %0d check failures.",
                 nopath_count, error_count);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
